FILE: rtl/ecd_pkg.sv
// ---------------------------------------------------------------------------
// ecd_pkg
// Shared constants, beat types and tables for the epoch to civil datetime
// pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecd_pkg;

	// pipeline depth, input register to output register
	localparam int NumStages = 20;

	// time of day split: 86400 = 128 * 675
	localparam int SecsPerDay   = 86400;
	localparam int DaySliceBits = 7;
	localparam int DayCore      = SecsPerDay >> DaySliceBits;
	localparam int SecsPerMin   = 60;

	// calendar constants
	localparam int DayShift    = 719468;
	localparam int DaysPerEra  = 146097;
	localparam int EraLastDay  = 146096;
	localparam int DaysPer4Yr  = 1460;
	localparam int DaysPerCent = 36524;
	localparam int DaysPerYear = 365;
	localparam int MonthSpan   = 153;
	localparam int MonthScale  = 5;
	localparam int MonthRound  = 2;
	localparam int YearsPerEra = 400;
	localparam int DaysPerWeek = 7;
	localparam int WdEpoch     = 4;

	// whole eras added so that every day count is non-negative
	localparam int EraBias  = 83;
	localparam int DayBias  = DayShift + EraBias * DaysPerEra;
	localparam int YearBias = EraBias * YearsPerEra;
	localparam int WdAdjust = (WdEpoch + DaysPerWeek - (DayBias % DaysPerWeek)) % DaysPerWeek;
	localparam logic [34:0] SecBias = 35'(longint'(DayBias) * longint'(DayCore));

	// truncated reciprocals, quotient estimate is exact or one low
	localparam int Rcp675Hi = (1 << 19) / DayCore;
	localparam int Rcp675Lo = (1 << 26) / DayCore;
	localparam int RcpEra   = (1 << 25) / DaysPerEra;
	localparam int RcpWeek  = (1 << 25) / DaysPerWeek;
	localparam int Rcp4Yr   = (1 << 18) / DaysPer4Yr;
	localparam int RcpCent  = (1 << 18) / DaysPerCent;
	localparam int RcpYear  = (1 << 18) / DaysPerYear;
	localparam int RcpMonth = (1 << 11) / MonthSpan;
	localparam int RcpSec   = (1 << 17) / SecsPerMin;
	localparam int RcpMin   = (1 << 11) / SecsPerMin;

	typedef struct packed {
		logic signed [16:0] year;
		logic [3:0]         month;
		logic [4:0]         mday;
		logic [2:0]         weekday;
	} date_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	typedef struct packed {
		date_t date;
		tod_t  tod;
	} beat_t;

	typedef struct packed {
		logic en;
		logic skid_load;
		logic skid_sel;
	} pipe_ctl_t;

	// first day of each march-based month, (153 * mp + 2) / 5
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] d;
		unique case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: rtl/ecd_pipe_ctrl.sv
// ---------------------------------------------------------------------------
// ecd_pipe_ctrl
// Valid bits of the pipeline and the output skid stage; produces the common
// advance enable and the skid controls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecd_pipe_ctrl import ecd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output pipe_ctl_t ctl
);

	logic [NumStages:1] vld_q;
	logic               skid_vld_q;

	// pipeline moves whenever the skid stage is free
	assign ctl.en        = !skid_vld_q;
	assign ctl.skid_load = !skid_vld_q && vld_q[NumStages] && out_stall;
	assign ctl.skid_sel  = skid_vld_q;

	assign in_stall  = skid_vld_q;
	assign out_valid = skid_vld_q || vld_q[NumStages];

	// valid bits and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			skid_vld_q <= 1'b0;
		end else begin
			if (ctl.en) begin
				vld_q <= {vld_q[NumStages-1:1], in_valid};
			end
			if (skid_vld_q) begin
				skid_vld_q <= out_stall;
			end else begin
				skid_vld_q <= vld_q[NumStages] && out_stall;
			end
		end
	end

endmodule

FILE: rtl/ecd_civil_date.sv
// ---------------------------------------------------------------------------
// ecd_civil_date
// Biased day count to year, month, day and weekday, stages 8 to 20, using
// the 400-year era method with reciprocal multiplies and one-step fix-ups.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecd_civil_date import ecd_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [24:0] zp,
	output date_t       date
);

	// stage 8
	logic [32:0] pe_s8;
	logic [47:0] pw_s8;
	logic [24:0] zp_s8;
	// stage 9
	logic [7:0]  erae_s9;
	logic [18:0] doee_s9;
	logic [3:0]  rwe_s9;
	// stage 10
	logic [7:0]  era_s10;
	logic [17:0] doe_s10;
	// stage 11
	logic [25:0] pa_s11;
	logic [20:0] pb_s11;
	logic        c_s11;
	logic [17:0] doe_s11;
	logic [7:0]  era_s11;
	// stage 12
	logic [7:0]  qae_s12;
	logic [11:0] rae_s12;
	logic [2:0]  qbe_s12;
	logic [16:0] rbe_s12;
	logic        c_s12;
	logic [17:0] doe_s12;
	logic [7:0]  era_s12;
	// stage 13
	logic [17:0] n_s13;
	logic [17:0] doe_s13;
	logic [7:0]  era_s13;
	// stage 14
	logic [27:0] py_s14;
	logic [17:0] n_s14;
	logic [17:0] doe_s14;
	logic [7:0]  era_s14;
	// stage 15
	logic [8:0]  yoee_s15;
	logic [9:0]  rye_s15;
	logic [17:0] doe_s15;
	logic [7:0]  era_s15;
	// stage 16
	logic [8:0]  yoe_s16;
	logic [17:0] doe_s16;
	logic [7:0]  era_s16;
	// stage 17 to 19
	logic [8:0]  doy_s17;
	logic [16:0] ybase_s17;
	logic [14:0] px_s18;
	logic [8:0]  doy_s18;
	logic [16:0] ybase_s18;
	logic [3:0]  mp_s19;
	logic [8:0]  doy_s19;
	logic [16:0] ybase_s19;
	// stage 20
	date_t       date_s20;
	// weekday travels from stage 10 to the end
	logic [2:0]  wd_s [10:NumStages-1];

	logic [24:0] doe_full;
	logic [24:0] wk_full;
	logic [3:0]  rw;
	logic [3:0]  wsum;
	logic [2:0]  wd_nxt;
	logic [17:0] ra_full;
	logic [17:0] rb_full;
	logic [7:0]  qa;
	logic [2:0]  qb;
	logic [17:0] ry_full;
	logic [1:0]  cent;
	logic [17:0] yd;
	logic [17:0] doy_full;
	logic [18:0] ybase_full;
	logic [10:0] x18;
	logic [10:0] x19;
	logic [10:0] rm;
	logic [3:0]  mpe;
	logic [3:0]  month_nxt;
	logic [8:0]  mday_full;

	// remainders of the estimated quotients
	always_comb begin
		doe_full = zp_s8 - 25'(pe_s8[32:25]) * 25'(DaysPerEra);
		wk_full  = zp_s8 - 25'(pw_s8[46:25]) * 25'(DaysPerWeek);
		ra_full  = doe_s11 - 18'(pa_s11[25:18]) * 18'(DaysPer4Yr);
		rb_full  = doe_s11 - 18'(pb_s11[20:18]) * 18'(DaysPerCent);
		ry_full  = n_s14 - 18'(py_s14[26:18]) * 18'(DaysPerYear);
	end

	// weekday fix-up and epoch offset
	always_comb begin
		rw     = (rwe_s9 >= 4'(DaysPerWeek)) ? rwe_s9 - 4'(DaysPerWeek) : rwe_s9;
		wsum   = rw + 4'(WdAdjust);
		wd_nxt = (wsum >= 4'(DaysPerWeek)) ? 3'(wsum - 4'(DaysPerWeek)) : wsum[2:0];
	end

	// leap corrections and year of era arithmetic
	always_comb begin
		qa = qae_s12 + 8'(rae_s12 >= 12'(DaysPer4Yr));
		qb = qbe_s12 + 3'(rbe_s12 >= 17'(DaysPerCent));
		priority if (yoe_s16 >= 9'd300) begin
			cent = 2'd3;
		end else if (yoe_s16 >= 9'd200) begin
			cent = 2'd2;
		end else if (yoe_s16 >= 9'd100) begin
			cent = 2'd1;
		end else begin
			cent = 2'd0;
		end
		yd         = 18'(yoe_s16) * 18'(DaysPerYear) + 18'(yoe_s16[8:2]) - 18'(cent);
		doy_full   = doe_s16 - yd;
		ybase_full = 19'(era_s16) * 19'(YearsPerEra) + 19'(yoe_s16) - 19'(YearBias);
	end

	// march-based month and day
	always_comb begin
		x18       = 11'(doy_s17) * 11'(MonthScale) + 11'(MonthRound);
		x19       = 11'(doy_s18) * 11'(MonthScale) + 11'(MonthRound);
		mpe       = px_s18[14:11];
		rm        = x19 - 11'(mpe) * 11'(MonthSpan);
		month_nxt = (mp_s19 < 4'd10) ? mp_s19 + 4'd3 : mp_s19 - 4'd9;
		mday_full = doy_s19 - month_start(mp_s19) + 9'd1;
	end

	// pipeline registers
	always_ff @(posedge clk) begin
		if (en) begin
			pe_s8  <= 33'(zp) * 33'(RcpEra);
			pw_s8  <= 48'(zp) * 48'(RcpWeek);
			zp_s8  <= zp;

			erae_s9 <= pe_s8[32:25];
			doee_s9 <= doe_full[18:0];
			rwe_s9  <= wk_full[3:0];

			if (doee_s9 >= 19'(DaysPerEra)) begin
				era_s10 <= erae_s9 + 8'd1;
				doe_s10 <= 18'(doee_s9 - 19'(DaysPerEra));
			end else begin
				era_s10 <= erae_s9;
				doe_s10 <= doee_s9[17:0];
			end
			wd_s[10] <= wd_nxt;

			pa_s11  <= 26'(doe_s10) * 26'(Rcp4Yr);
			pb_s11  <= 21'(doe_s10) * 21'(RcpCent);
			c_s11   <= (doe_s10 == 18'(EraLastDay));
			doe_s11 <= doe_s10;
			era_s11 <= era_s10;

			qae_s12 <= pa_s11[25:18];
			rae_s12 <= ra_full[11:0];
			qbe_s12 <= pb_s11[20:18];
			rbe_s12 <= rb_full[16:0];
			c_s12   <= c_s11;
			doe_s12 <= doe_s11;
			era_s12 <= era_s11;

			n_s13   <= doe_s12 + 18'(qb) - 18'(qa) - 18'(c_s12);
			doe_s13 <= doe_s12;
			era_s13 <= era_s12;

			py_s14  <= 28'(n_s13) * 28'(RcpYear);
			n_s14   <= n_s13;
			doe_s14 <= doe_s13;
			era_s14 <= era_s13;

			yoee_s15 <= py_s14[26:18];
			rye_s15  <= ry_full[9:0];
			doe_s15  <= doe_s14;
			era_s15  <= era_s14;

			yoe_s16 <= yoee_s15 + 9'(rye_s15 >= 10'(DaysPerYear));
			doe_s16 <= doe_s15;
			era_s16 <= era_s15;

			doy_s17   <= doy_full[8:0];
			ybase_s17 <= ybase_full[16:0];

			px_s18    <= 15'(x18) * 15'(RcpMonth);
			doy_s18   <= doy_s17;
			ybase_s18 <= ybase_s17;

			mp_s19    <= mpe + 4'(rm >= 11'(MonthSpan));
			doy_s19   <= doy_s18;
			ybase_s19 <= ybase_s18;

			date_s20.month   <= month_nxt;
			date_s20.mday    <= mday_full[4:0];
			date_s20.year    <= ybase_s19 + 17'(month_nxt <= 4'd2);
			date_s20.weekday <= wd_s[NumStages-1];

			for (int i = 11; i < NumStages; i++) begin
				wd_s[i] <= wd_s[i-1];
			end
		end
	end

	assign date = date_s20;

endmodule

FILE: rtl/epoch_seconds_to_civil_datetime_core.sv
// ---------------------------------------------------------------------------
// epoch_seconds_to_civil_datetime_core
// Converts a signed 41-bit count of seconds since 1970-01-01 00:00:00 UTC
// into proleptic Gregorian year, month, day, weekday and time of day. The
// block is a fully pipelined 20-stage datapath: it takes one beat per clock
// while the input is not stalled. Every division is by a constant, done as a
// reciprocal multiply followed by a one-step correction, so no stage has more
// than one multiply on any path. A skid register on the output keeps the
// pipeline moving for one extra beat when the output is stalled; the input
// stall is a register. The block keeps no state beyond the beats in flight
// and has no configuration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_seconds_to_civil_datetime_core import ecd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [40:0] epoch_seconds,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] year,
	output logic [3:0]         month,
	output logic [4:0]         day,
	output logic [2:0]         weekday,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second
);

	pipe_ctl_t   ctl;

	// day split stages
	logic [34:0] u_s1;
	logic [6:0]  lo7_s1;
	logic [28:0] p1_s2;
	logic [18:0] uh_s2;
	logic [15:0] ul_s2;
	logic [6:0]  lo7_s2;
	logic [9:0]  q1e_s3;
	logic [10:0] r1e_s3;
	logic [15:0] ul_s3;
	logic [6:0]  lo7_s3;
	logic [9:0]  q1_s4;
	logic [25:0] v_s4;
	logic [6:0]  lo7_s4;
	logic [42:0] p2_s5;
	logic [25:0] v_s5;
	logic [9:0]  q1_s5;
	logic [6:0]  lo7_s5;
	logic [15:0] q2e_s6;
	logic [10:0] r2e_s6;
	logic [9:0]  q1_s6;
	logic [6:0]  lo7_s6;
	logic [24:0] zp_s7;
	logic [16:0] rem_s7;

	// time of day stages
	logic [28:0] pt_s8;
	logic [16:0] rem_s8;
	logic [10:0] q60e_s9;
	logic [6:0]  r60e_s9;
	logic [10:0] q60_s10;
	logic [5:0]  sec_s10;
	logic [15:0] ph_s11;
	logic [10:0] q60_s11;
	logic [5:0]  sec_s11;
	logic [4:0]  he_s12;
	logic [6:0]  rhe_s12;
	logic [5:0]  sec_s12;
	tod_t        tod_s [13:NumStages];

	date_t       date_s20;
	beat_t       beat_s20;
	beat_t       skid_q;
	beat_t       beat_out;

	logic [34:0] u_nxt;
	logic [9:0]  q1;
	logic [9:0]  r1;
	logic [15:0] q2;
	logic [9:0]  r2;
	logic [25:0] zp_wide;
	logic [18:0] r1_full;
	logic [25:0] r2_full;
	logic [16:0] r60_full;
	logic [10:0] rh_full;
	tod_t        tod_nxt;

	ecd_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	// floor split into 128-second slices, biased so the count is positive
	assign u_nxt = {epoch_seconds[40], epoch_seconds[40:DaySliceBits]} + SecBias;

	// estimate remainders and fix-ups of the two divisions by 675
	always_comb begin
		r1_full = uh_s2 - 19'(p1_s2[28:19]) * 19'(DayCore);
		r2_full = v_s5 - 26'(p2_s5[41:26]) * 26'(DayCore);
		if (r1e_s3 >= 11'(DayCore)) begin
			q1 = q1e_s3 + 10'd1;
			r1 = 10'(r1e_s3 - 11'(DayCore));
		end else begin
			q1 = q1e_s3;
			r1 = r1e_s3[9:0];
		end
		if (r2e_s6 >= 11'(DayCore)) begin
			q2 = q2e_s6 + 16'd1;
			r2 = 10'(r2e_s6 - 11'(DayCore));
		end else begin
			q2 = q2e_s6;
			r2 = r2e_s6[9:0];
		end
		zp_wide = {q1_s6, q2};
	end

	// seconds, minutes and hours from the second of the day
	always_comb begin
		r60_full = rem_s8 - 17'(pt_s8[27:17]) * 17'(SecsPerMin);
		rh_full  = q60_s11 - 11'(ph_s11[15:11]) * 11'(SecsPerMin);
		tod_nxt.second = sec_s12;
		if (rhe_s12 >= 7'(SecsPerMin)) begin
			tod_nxt.hour   = he_s12 + 5'd1;
			tod_nxt.minute = 6'(rhe_s12 - 7'(SecsPerMin));
		end else begin
			tod_nxt.hour   = he_s12;
			tod_nxt.minute = rhe_s12[5:0];
		end
	end

	// pipeline registers
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			u_s1   <= u_nxt;
			lo7_s1 <= epoch_seconds[DaySliceBits-1:0];

			p1_s2  <= 29'(u_s1[34:16]) * 29'(Rcp675Hi);
			uh_s2  <= u_s1[34:16];
			ul_s2  <= u_s1[15:0];
			lo7_s2 <= lo7_s1;

			q1e_s3 <= p1_s2[28:19];
			r1e_s3 <= r1_full[10:0];
			ul_s3  <= ul_s2;
			lo7_s3 <= lo7_s2;

			q1_s4  <= q1;
			v_s4   <= {r1, ul_s3};
			lo7_s4 <= lo7_s3;

			p2_s5  <= 43'(v_s4) * 43'(Rcp675Lo);
			v_s5   <= v_s4;
			q1_s5  <= q1_s4;
			lo7_s5 <= lo7_s4;

			q2e_s6 <= p2_s5[41:26];
			r2e_s6 <= r2_full[10:0];
			q1_s6  <= q1_s5;
			lo7_s6 <= lo7_s5;

			zp_s7  <= zp_wide[24:0];
			rem_s7 <= {r2, lo7_s6};

			pt_s8  <= 29'(rem_s7) * 29'(RcpSec);
			rem_s8 <= rem_s7;

			q60e_s9 <= pt_s8[27:17];
			r60e_s9 <= r60_full[6:0];

			if (r60e_s9 >= 7'(SecsPerMin)) begin
				q60_s10 <= q60e_s9 + 11'd1;
				sec_s10 <= 6'(r60e_s9 - 7'(SecsPerMin));
			end else begin
				q60_s10 <= q60e_s9;
				sec_s10 <= r60e_s9[5:0];
			end

			ph_s11  <= 16'(q60_s10) * 16'(RcpMin);
			q60_s11 <= q60_s10;
			sec_s11 <= sec_s10;

			he_s12  <= ph_s11[15:11];
			rhe_s12 <= rh_full[6:0];
			sec_s12 <= sec_s11;

			tod_s[13] <= tod_nxt;
			for (int i = 14; i <= NumStages; i++) begin
				tod_s[i] <= tod_s[i-1];
			end
		end
	end

	// calendar date, stages 8 to 20
	ecd_civil_date u_civil (
		.clk  (clk),
		.en   (ctl.en),
		.zp   (zp_s7),
		.date (date_s20)
	);

	assign beat_s20.date = date_s20;
	assign beat_s20.tod  = tod_s[NumStages];

	// output skid stage
	always_ff @(posedge clk) begin
		if (ctl.skid_load) begin
			skid_q <= beat_s20;
		end
	end

	assign beat_out = ctl.skid_sel ? skid_q : beat_s20;
	assign year     = beat_out.date.year;
	assign month    = beat_out.date.month;
	assign day      = beat_out.date.mday;
	assign weekday  = beat_out.date.weekday;
	assign hour     = beat_out.tod.hour;
	assign minute   = beat_out.tod.minute;
	assign second   = beat_out.tod.second;

	// date fields of a valid beat stay in range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1)
			&& (weekday <= 3'd6))
		else $error("date field out of range on output beat");

	// time fields of a valid beat stay in range
	a_tod_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
		else $error("time field out of range on output beat");

	// input is only held off when a result is waiting
	a_stall_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output beat pending");

	// skid fills only from a stalled output beat
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("skid stage filled without a stalled output beat");

endmodule
